/* src/booth_radix4_multiplier_unit_macros.svh */
// Assertion macros shared by the Booth multiplier RTL.
`ifndef BOOTH_RADIX4_MULTIPLIER_UNIT_MACROS_SVH
`define BOOTH_RADIX4_MULTIPLIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BR4M_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BR4M_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/br4m_pkg.sv */
// Package with the Booth digit selection type and its decoder.
package br4m_pkg;

   typedef struct packed {
      logic neg;
      logic one;
      logic two;
   } booth_sel_type;

   function automatic booth_sel_type booth_decode(input logic [2:0] bits);
      booth_sel_type sel;
      sel = '0;
      case (bits)
         3'b000: sel = '0;
         3'b001: sel.one = 1'b1;
         3'b010: sel.one = 1'b1;
         3'b011: sel.two = 1'b1;
         3'b100: begin
            sel.two = 1'b1;
            sel.neg = 1'b1;
         end
         3'b101: begin
            sel.one = 1'b1;
            sel.neg = 1'b1;
         end
         3'b110: begin
            sel.one = 1'b1;
            sel.neg = 1'b1;
         end
         3'b111: sel = '0;
         default: sel = '0;
      endcase
      return sel;
   endfunction

endpackage

/* src/booth_radix4_multiplier_unit.sv */
// Top level of the signed radix-4 Booth multiplier with registered operands and product.
//
//   Channel   Direction  Ports                                   Handshake
//   request   in         req_multiplicand, req_multiplier        start, busy
//   response  out        rsp_product                             rsp_valid
//
// A word is taken at every clock edge with start high and busy low, one word per cycle.
// Its product then appears on rsp_product with rsp_valid, for one cycle.
// The latency is set by the operand register and the product register around the adder.
// Reset clears both valid flags; busy is high only while reset is asserted.
// The receiver cannot stall, so the block never holds off the sender after reset.
`include "booth_radix4_multiplier_unit_macros.svh"

module booth_radix4_multiplier_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OPERAND_WIDTH-1:0]     req_multiplicand,
   input  logic [OPERAND_WIDTH-1:0]     req_multiplier,
   output logic                         rsp_valid,
   output logic [2*OPERAND_WIDTH-1:0]   rsp_product
);
   import br4m_pkg::*;

   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int ND = (OPERAND_WIDTH + 1) / 2;
   localparam int QW = 2 * ND + 1;

   logic                     valid_ff;
   logic                     valid_in;
   logic [OPERAND_WIDTH-1:0] mcand_ff;
   logic [OPERAND_WIDTH-1:0] mplier_ff;
   logic                     rsp_valid_ff;
   logic [PW-1:0]            rsp_product_ff;
   logic [PW-1:0]            product_in;

   logic signed [PW-1:0]     mcand_wide;
   logic signed [PW-1:0]     mplier_wide;
   logic [QW-1:0]            mplier_rec;
   logic                     accept;

   assign busy   = reset;
   assign accept = start && !busy;
   assign valid_in = accept;

   assign mcand_wide  = {{OPERAND_WIDTH{mcand_ff[OPERAND_WIDTH-1]}}, mcand_ff};
   assign mplier_wide = {{OPERAND_WIDTH{mplier_ff[OPERAND_WIDTH-1]}}, mplier_ff};
   // The multiplier is sign-extended to an even width with a zero below its lowest bit.
   assign mplier_rec  = {mplier_wide[QW-2:0], 1'b0};

   always_comb begin
      logic [PW-1:0] acc;
      logic [PW-1:0] pp;
      booth_sel_type sel;
      acc = '0;
      for (int i = 0; i < ND; i++) begin
         sel = booth_decode(mplier_rec[2*i +: 3]);
         pp  = '0;
         if (sel.one) begin
            pp = mcand_wide;
         end else if (sel.two) begin
            pp = {mcand_wide[PW-2:0], 1'b0};
         end
         if (sel.neg) begin
            pp = ~pp + {{(PW-1){1'b0}}, 1'b1};
         end
         acc = acc + (pp << (2 * i));
      end
      product_in = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mcand_ff  <= req_multiplicand;
         mplier_ff <= req_multiplier;
      end
      if (valid_ff) begin
         rsp_product_ff <= product_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;

   `BR4M_ASSERT_NEXT(a_accept_loads, accept, valid_ff)
   `BR4M_ASSERT_NEXT(a_stage_to_rsp, valid_ff, rsp_valid_ff)
   `BR4M_ASSERT_SAME(a_rsp_has_source, rsp_valid_ff, $past(valid_ff))
   `BR4M_ASSERT_NEXT(a_product_exact, valid_ff, rsp_product_ff == $past(mcand_wide * mplier_wide))

endmodule

/* tb/tb_booth_radix4_multiplier_unit.sv */
// Self-checking testbench for the radix-4 Booth multiplier unit with random operands and gaps.
module tb_booth_radix4_multiplier_unit;

   localparam int W = 16;

   typedef struct {
      logic [W-1:0]   mcand;
      logic [W-1:0]   mplier;
      logic [2*W-1:0] product;
   } product_entry_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [W-1:0]     req_multiplicand;
   logic [W-1:0]     req_multiplier;
   logic             rsp_valid;
   logic [2*W-1:0]   rsp_product;

   product_entry_type pending_products[$];
   int               error_count;
   int               mismatch_count;

   booth_radix4_multiplier_unit #(
      .OPERAND_WIDTH(W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_multiplicand (req_multiplicand),
      .req_multiplier   (req_multiplier),
      .rsp_valid        (rsp_valid),
      .rsp_product      (rsp_product)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [2*W-1:0] booth_product(input logic [W-1:0] mcand,
                                                    input logic [W-1:0] mplier);
      logic [2*W-1:0] m_ext;
      logic [2*W-1:0] acc;
      logic [2*W-1:0] partial;
      logic [W:0]     q_ext;
      logic [2:0]     triple;
      int             i;
      m_ext = {{W{mcand[W-1]}}, mcand};
      q_ext = {mplier, 1'b0};
      acc = '0;
      for (i = 0; i < W / 2; i++) begin
         triple = q_ext[2*i +: 3];
         case (triple)
            3'b001, 3'b010: partial = m_ext;
            3'b011:         partial = m_ext << 1;
            3'b100:         partial = -(m_ext << 1);
            3'b101, 3'b110: partial = -m_ext;
            default:        partial = '0;
         endcase
         acc = acc + (partial << (2 * i));
      end
      return acc;
   endfunction

   function automatic logic [W-1:0] operand_sample();
      logic [W-1:0] value;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: value = {1'b1, {(W-1){1'b0}}};
               1: value = {1'b0, {(W-1){1'b1}}};
               2: value = '0;
               3: value = '1;
               default: value = W'(1);
            endcase
         end
         1: value = W'($signed($urandom_range(0, 15)) - 8);
         2: value = W'(1) << $urandom_range(0, W - 1);
         default: value = W'($urandom);
      endcase
      return value;
   endfunction

   task automatic send_word(input logic [W-1:0] mcand, input logic [W-1:0] mplier);
      product_entry_type entry;
      @(negedge clock);
      start <= 1'b1;
      req_multiplicand <= mcand;
      req_multiplier <= mplier;
      do @(posedge clock); while (busy);
      entry.mcand = mcand;
      entry.mplier = mplier;
      entry.product = booth_product(mcand, mplier);
      pending_products.push_back(entry);
   endtask

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_for_drain();
      idle_cycles(1);
      while (pending_products.size() != 0) @(posedge clock);
      idle_cycles(3);
   endtask

   task automatic test_corner_operands();
      logic [W-1:0] corners[5];
      corners[0] = {1'b1, {(W-1){1'b0}}};
      corners[1] = {1'b0, {(W-1){1'b1}}};
      corners[2] = '0;
      corners[3] = W'(1);
      corners[4] = '1;
      foreach (corners[i]) begin
         foreach (corners[j]) begin
            send_word(corners[i], corners[j]);
         end
      end
   endtask

   task automatic test_random_bursts(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < count) begin
            send_word(operand_sample(), operand_sample());
            burst--;
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 6));
         end
      end
   endtask

   task automatic test_back_to_back(input int count);
      repeat (count) begin
         send_word(W'($urandom), W'($urandom));
      end
   endtask

   always @(posedge clock) begin : check_products
      product_entry_type head;
      if (!reset && rsp_valid) begin
         if (pending_products.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected product word %0d", $signed(rsp_product));
            end
         end else begin
            head = pending_products.pop_front();
            if (rsp_product !== head.product) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Product mismatch for %0d * %0d: expected %0d, got %0d",
                           $signed(head.mcand), $signed(head.mplier),
                           $signed(head.product), $signed(rsp_product));
               end
            end
         end
      end
   end

   initial begin
      error_count = 0;
      mismatch_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_multiplicand = '0;
      req_multiplier = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_operands();
      test_random_bursts(600);
      wait_for_drain();
      test_back_to_back(200);
      test_random_bursts(475);
      wait_for_drain();

      repeat (4) @(posedge clock);
      error_count = error_count + pending_products.size();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
